[rtl/core/msb_first_bit_reader_top_defines.svh]
// assertion macros used by the checker file
`ifndef MSB_FIRST_BIT_READER_TOP_DEFINES_SVH
`define MSB_FIRST_BIT_READER_TOP_DEFINES_SVH

// same-cycle implication, checked on every clk edge outside reset
`define MSBR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked on every clk edge outside reset
`define MSBR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/core/msbr_pkg.sv]
package msbr_pkg;

  // item kinds carried on the input tuser
  typedef enum logic [1:0] {
    KIND_BYTE    = 2'd0,
    KIND_REQUEST = 2'd1,
    KIND_END     = 2'd2,
    KIND_REWIND  = 2'd3
  } kind_t;

  // result status carried on the output tuser
  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_END      = 2'd1,
    ST_BUSY     = 2'd2,
    ST_OVERFLOW = 2'd3
  } status_t;

  localparam int VALUE_W = 64;
  localparam int WIDTH_W = 7;
  localparam int BYTE_W  = 8;

endpackage

[rtl/core/msbr_take.sv]
// pulls the oldest take_w bits off the top of the valid window
module msbr_take #(
  parameter int STORE_BITS = 72,
  parameter int CNT_W      = 7
) (
  input  logic [STORE_BITS-1:0]          store_in,
  input  logic [CNT_W-1:0]               count_in,
  input  logic [msbr_pkg::WIDTH_W-1:0]   take_w,
  output logic [msbr_pkg::VALUE_W-1:0]   value,
  output logic [STORE_BITS-1:0]          store_out,
  output logic [CNT_W-1:0]               count_out
);

  localparam int XW = (STORE_BITS > msbr_pkg::VALUE_W) ? STORE_BITS : msbr_pkg::VALUE_W;

  logic [CNT_W-1:0] rest;
  logic [XW-1:0]    wide;

  // bits left behind after the take
  assign rest = count_in - CNT_W'(take_w);

  // barrel shift the window down, keep the low take_w bits
  always_comb begin
    wide  = XW'(store_in) >> rest;
    value = wide[msbr_pkg::VALUE_W-1:0] & ~({msbr_pkg::VALUE_W{1'b1}} << take_w);
  end

  // clear the consumed bits
  assign store_out = store_in & ~({STORE_BITS{1'b1}} << rest);
  assign count_out = rest;

endmodule

[rtl/core/msb_first_bit_reader_top.sv]
// channel  | dir | tdata                               | tuser
// ---------+-----+-------------------------------------+--------------------
// s_axis   | in  | [7:0] data_byte, [14:8] width       | [1:0] kind
// m_axis   | out | [63:0] value                        | [1:0] status
//
// one beat accepted per cycle while s_axis_tready is high; a result passes from
// the input register through one barrel shift of the bit store into the result
// register, from which it leaves on m_axis.
// rst is synchronous and clears the store, counters and both valid flags.
// s_axis_tready drops only while the input register holds a beat and the
// output register holds a result that m_axis has not taken.
module msb_first_bit_reader_top #(
  parameter int MAX_WIDTH = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,  // [7:0] data_byte, [14:8] width, [15] zero
  input  logic [1:0]  s_axis_tuser,  // [1:0] kind
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,  // [63:0] value
  output logic [1:0]  m_axis_tuser   // [1:0] status
);

  localparam int STORE_BITS = MAX_WIDTH + msbr_pkg::BYTE_W;
  localparam int CNT_W      = $clog2(STORE_BITS + 1);
  localparam int CMP_W      = (CNT_W + 1 > msbr_pkg::WIDTH_W) ? CNT_W + 1 : msbr_pkg::WIDTH_W;
  localparam logic [msbr_pkg::WIDTH_W-1:0] MAX_W = msbr_pkg::WIDTH_W'(MAX_WIDTH);

  // input register
  logic                              in_valid;
  msbr_pkg::kind_t                   in_kind;
  logic [msbr_pkg::BYTE_W-1:0]       in_byte;
  logic [msbr_pkg::WIDTH_W-1:0]      in_width;

  // reader state
  logic [STORE_BITS-1:0]             bit_store, bit_store_next;
  logic [CNT_W-1:0]                  bit_count, bit_count_next;
  logic                              pending, pending_next;
  logic [msbr_pkg::WIDTH_W-1:0]      pend_width, pend_width_next;
  logic                              ended, ended_next;

  // result register
  logic                              out_valid;
  logic [msbr_pkg::VALUE_W-1:0]      out_value;
  msbr_pkg::status_t                 out_status;

  logic                              fire;
  logic                              res_valid;
  logic [msbr_pkg::VALUE_W-1:0]      res_value;
  msbr_pkg::status_t                 res_status;

  logic [msbr_pkg::WIDTH_W-1:0]      sat_w;
  logic [CMP_W-1:0]                  app_count;
  logic                              overflow;
  logic [STORE_BITS-1:0]             app_store;

  logic [STORE_BITS-1:0]             take_store;
  logic [CNT_W-1:0]                  take_count;
  logic [msbr_pkg::WIDTH_W-1:0]      take_w;
  logic [msbr_pkg::VALUE_W-1:0]      take_value;
  logic [STORE_BITS-1:0]             take_store_out;
  logic [CNT_W-1:0]                  take_count_out;

  // handshake
  assign fire          = in_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !in_valid || fire;
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_value;
  assign m_axis_tuser  = out_status;

  // capture input beat
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
    if (s_axis_tvalid && s_axis_tready) begin
      in_kind  <= msbr_pkg::kind_t'(s_axis_tuser);
      in_byte  <= s_axis_tdata[7:0];
      in_width <= s_axis_tdata[14:8];
    end
  end

  // byte append and width saturation
  always_comb begin
    sat_w     = (in_width > MAX_W) ? MAX_W : in_width;
    app_count = CMP_W'(bit_count) + CMP_W'(msbr_pkg::BYTE_W);
    overflow  = app_count > CMP_W'(STORE_BITS);
    app_store = {bit_store[STORE_BITS-msbr_pkg::BYTE_W-1:0], in_byte};
  end

  // a byte completes the pending request, a request takes from the current store
  always_comb begin
    if (in_kind == msbr_pkg::KIND_BYTE) begin
      take_store = app_store;
      take_count = CNT_W'(app_count);
      take_w     = pend_width;
    end else begin
      take_store = bit_store;
      take_count = bit_count;
      take_w     = sat_w;
    end
  end

  msbr_take #(
    .STORE_BITS (STORE_BITS),
    .CNT_W      (CNT_W)
  ) u_take (
    .store_in  (take_store),
    .count_in  (take_count),
    .take_w    (take_w),
    .value     (take_value),
    .store_out (take_store_out),
    .count_out (take_count_out)
  );

  // next state and result
  always_comb begin
    bit_store_next  = bit_store;
    bit_count_next  = bit_count;
    pending_next    = pending;
    pend_width_next = pend_width;
    ended_next      = ended;
    res_valid       = 1'b0;
    res_value       = '0;
    res_status      = msbr_pkg::ST_OK;
    case (in_kind)
      msbr_pkg::KIND_BYTE: begin
        if (overflow) begin
          res_valid  = 1'b1;
          res_status = msbr_pkg::ST_OVERFLOW;
        end else if (pending && app_count >= CMP_W'(pend_width)) begin
          bit_store_next = take_store_out;
          bit_count_next = take_count_out;
          pending_next   = 1'b0;
          res_valid      = 1'b1;
          res_value      = take_value;
        end else begin
          bit_store_next = app_store;
          bit_count_next = CNT_W'(app_count);
        end
      end
      msbr_pkg::KIND_REQUEST: begin
        if (pending) begin
          res_valid  = 1'b1;
          res_status = msbr_pkg::ST_BUSY;
        end else if (in_width == '0) begin
          res_valid = 1'b1;
        end else if (CMP_W'(bit_count) >= CMP_W'(sat_w)) begin
          bit_store_next = take_store_out;
          bit_count_next = take_count_out;
          res_valid      = 1'b1;
          res_value      = take_value;
        end else if (ended) begin
          res_valid  = 1'b1;
          res_status = msbr_pkg::ST_END;
        end else begin
          pending_next    = 1'b1;
          pend_width_next = sat_w;
        end
      end
      msbr_pkg::KIND_END: begin
        ended_next = 1'b1;
        if (pending) begin
          pending_next    = 1'b0;
          pend_width_next = '0;
          res_valid       = 1'b1;
          res_status      = msbr_pkg::ST_END;
        end
      end
      msbr_pkg::KIND_REWIND: begin
        bit_store_next  = '0;
        bit_count_next  = '0;
        pending_next    = 1'b0;
        pend_width_next = '0;
        ended_next      = 1'b0;
      end
      default: begin
        bit_store_next = bit_store;
      end
    endcase
  end

  // state update
  always_ff @(posedge clk) begin
    if (rst) begin
      bit_store  <= '0;
      bit_count  <= '0;
      pending    <= 1'b0;
      pend_width <= '0;
      ended      <= 1'b0;
    end else if (fire) begin
      bit_store  <= bit_store_next;
      bit_count  <= bit_count_next;
      pending    <= pending_next;
      pend_width <= pend_width_next;
      ended      <= ended_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= res_valid;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
    if (fire && res_valid) begin
      out_value  <= res_value;
      out_status <= res_status;
    end
  end

endmodule

[rtl/core/msbr_checker.sv]
`include "msb_first_bit_reader_top_defines.svh"

// port-level checks on the bit reader
module msbr_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [63:0] m_axis_tdata,
  input logic [1:0]  m_axis_tuser
);

  // a stalled result beat holds
  `MSBR_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "stalled result beat changed")

  // every failure status carries a zero value
  `MSBR_ASSERT_NOW(a_err_zero, m_axis_tvalid && (m_axis_tuser != msbr_pkg::ST_OK), m_axis_tdata == '0, "non-ok result with nonzero value")

  // a taking sink never backs up the input
  `MSBR_ASSERT_NOW(a_ready_pass, m_axis_tready, s_axis_tready, "input stalled while sink is ready")

  // a fresh result must trace back to an accepted input beat
  `MSBR_ASSERT_NOW(a_res_src, $rose(m_axis_tvalid), $past(s_axis_tvalid && s_axis_tready, 2), "result without input beat")

endmodule

bind msb_first_bit_reader_top msbr_checker u_msbr_checker (.*);
